// ===== sv/dcu_pkg.sv =====
// ----------------------------------------------------------------------------
// dcu_pkg
// Shared constants, types and the prime table for the divisor count unit.
// ----------------------------------------------------------------------------
package dcu_pkg;

  localparam int VALUE_WIDTH = 24;
  localparam int PRIME_COUNT = 564;
  localparam int PRIME_WIDTH = 12;
  localparam int COUNT_WIDTH = 10;

  localparam int INDEX_WIDTH = $clog2(PRIME_COUNT);
  localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);
  localparam int EXP_WIDTH   = $clog2(VALUE_WIDTH + 1);
  localparam int SAT_WIDTH   = COUNT_WIDTH + 1;
  localparam int PROD_WIDTH  = SAT_WIDTH + EXP_WIDTH;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [PRIME_WIDTH-1:0] prime_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [SAT_WIDTH-1:0]   sat_t;
  typedef logic [PROD_WIDTH-1:0]  prod_t;
  typedef logic [INDEX_WIDTH-1:0] index_t;
  typedef logic [STEP_WIDTH-1:0]  step_t;
  typedef logic [EXP_WIDTH-1:0]   exp_t;

  localparam count_t COUNT_MAX  = '1;
  localparam sat_t   COUNT_SAT  = SAT_WIDTH'(2 ** COUNT_WIDTH);
  localparam index_t INDEX_LAST = INDEX_WIDTH'(PRIME_COUNT - 1);
  localparam step_t  STEP_LAST  = STEP_WIDTH'(VALUE_WIDTH - 1);

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_FETCH,
    ST_CHECK,
    ST_DIVIDE,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic   start;
    value_t dividend;
    prime_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    value_t quotient;
    prime_t remainder;
  } div_rsp_t;

  // primes below 4096, ascending
  localparam prime_t PRIME_TABLE [PRIME_COUNT] = '{
    12'd2, 12'd3, 12'd5, 12'd7, 12'd11, 12'd13, 12'd17, 12'd19, 12'd23, 12'd29,
    12'd31, 12'd37, 12'd41, 12'd43, 12'd47, 12'd53, 12'd59, 12'd61, 12'd67, 12'd71,
    12'd73, 12'd79, 12'd83, 12'd89, 12'd97,
    12'd101, 12'd103, 12'd107, 12'd109, 12'd113, 12'd127, 12'd131, 12'd137, 12'd139,
    12'd149, 12'd151, 12'd157, 12'd163, 12'd167, 12'd173, 12'd179, 12'd181, 12'd191,
    12'd193, 12'd197, 12'd199,
    12'd211, 12'd223, 12'd227, 12'd229, 12'd233, 12'd239, 12'd241, 12'd251, 12'd257,
    12'd263, 12'd269, 12'd271, 12'd277, 12'd281, 12'd283, 12'd293,
    12'd307, 12'd311, 12'd313, 12'd317, 12'd331, 12'd337, 12'd347, 12'd349, 12'd353,
    12'd359, 12'd367, 12'd373, 12'd379, 12'd383, 12'd389, 12'd397,
    12'd401, 12'd409, 12'd419, 12'd421, 12'd431, 12'd433, 12'd439, 12'd443, 12'd449,
    12'd457, 12'd461, 12'd463, 12'd467, 12'd479, 12'd487, 12'd491, 12'd499,
    12'd503, 12'd509, 12'd521, 12'd523, 12'd541, 12'd547, 12'd557, 12'd563, 12'd569,
    12'd571, 12'd577, 12'd587, 12'd593, 12'd599,
    12'd601, 12'd607, 12'd613, 12'd617, 12'd619, 12'd631, 12'd641, 12'd643, 12'd647,
    12'd653, 12'd659, 12'd661, 12'd673, 12'd677, 12'd683, 12'd691,
    12'd701, 12'd709, 12'd719, 12'd727, 12'd733, 12'd739, 12'd743, 12'd751, 12'd757,
    12'd761, 12'd769, 12'd773, 12'd787, 12'd797,
    12'd809, 12'd811, 12'd821, 12'd823, 12'd827, 12'd829, 12'd839, 12'd853, 12'd857,
    12'd859, 12'd863, 12'd877, 12'd881, 12'd883, 12'd887,
    12'd907, 12'd911, 12'd919, 12'd929, 12'd937, 12'd941, 12'd947, 12'd953, 12'd967,
    12'd971, 12'd977, 12'd983, 12'd991, 12'd997,
    12'd1009, 12'd1013, 12'd1019, 12'd1021, 12'd1031, 12'd1033, 12'd1039, 12'd1049,
    12'd1051, 12'd1061, 12'd1063, 12'd1069, 12'd1087, 12'd1091, 12'd1093, 12'd1097,
    12'd1103, 12'd1109, 12'd1117, 12'd1123, 12'd1129, 12'd1151, 12'd1153, 12'd1163,
    12'd1171, 12'd1181, 12'd1187, 12'd1193,
    12'd1201, 12'd1213, 12'd1217, 12'd1223, 12'd1229, 12'd1231, 12'd1237, 12'd1249,
    12'd1259, 12'd1277, 12'd1279, 12'd1283, 12'd1289, 12'd1291, 12'd1297,
    12'd1301, 12'd1303, 12'd1307, 12'd1319, 12'd1321, 12'd1327, 12'd1361, 12'd1367,
    12'd1373, 12'd1381, 12'd1399,
    12'd1409, 12'd1423, 12'd1427, 12'd1429, 12'd1433, 12'd1439, 12'd1447, 12'd1451,
    12'd1453, 12'd1459, 12'd1471, 12'd1481, 12'd1483, 12'd1487, 12'd1489, 12'd1493,
    12'd1499,
    12'd1511, 12'd1523, 12'd1531, 12'd1543, 12'd1549, 12'd1553, 12'd1559, 12'd1567,
    12'd1571, 12'd1579, 12'd1583, 12'd1597,
    12'd1601, 12'd1607, 12'd1609, 12'd1613, 12'd1619, 12'd1621, 12'd1627, 12'd1637,
    12'd1657, 12'd1663, 12'd1667, 12'd1669, 12'd1693, 12'd1697, 12'd1699,
    12'd1709, 12'd1721, 12'd1723, 12'd1733, 12'd1741, 12'd1747, 12'd1753, 12'd1759,
    12'd1777, 12'd1783, 12'd1787, 12'd1789,
    12'd1801, 12'd1811, 12'd1823, 12'd1831, 12'd1847, 12'd1861, 12'd1867, 12'd1871,
    12'd1873, 12'd1877, 12'd1879, 12'd1889,
    12'd1901, 12'd1907, 12'd1913, 12'd1931, 12'd1933, 12'd1949, 12'd1951, 12'd1973,
    12'd1979, 12'd1987, 12'd1993, 12'd1997, 12'd1999,
    12'd2003, 12'd2011, 12'd2017, 12'd2027, 12'd2029, 12'd2039, 12'd2053, 12'd2063,
    12'd2069, 12'd2081, 12'd2083, 12'd2087, 12'd2089, 12'd2099,
    12'd2111, 12'd2113, 12'd2129, 12'd2131, 12'd2137, 12'd2141, 12'd2143, 12'd2153,
    12'd2161, 12'd2179,
    12'd2203, 12'd2207, 12'd2213, 12'd2221, 12'd2237, 12'd2239, 12'd2243, 12'd2251,
    12'd2267, 12'd2269, 12'd2273, 12'd2281, 12'd2287, 12'd2293, 12'd2297,
    12'd2309, 12'd2311, 12'd2333, 12'd2339, 12'd2341, 12'd2347, 12'd2351, 12'd2357,
    12'd2371, 12'd2377, 12'd2381, 12'd2383, 12'd2389, 12'd2393, 12'd2399,
    12'd2411, 12'd2417, 12'd2423, 12'd2437, 12'd2441, 12'd2447, 12'd2459, 12'd2467,
    12'd2473, 12'd2477,
    12'd2503, 12'd2521, 12'd2531, 12'd2539, 12'd2543, 12'd2549, 12'd2551, 12'd2557,
    12'd2579, 12'd2591, 12'd2593,
    12'd2609, 12'd2617, 12'd2621, 12'd2633, 12'd2647, 12'd2657, 12'd2659, 12'd2663,
    12'd2671, 12'd2677, 12'd2683, 12'd2687, 12'd2689, 12'd2693, 12'd2699,
    12'd2707, 12'd2711, 12'd2713, 12'd2719, 12'd2729, 12'd2731, 12'd2741, 12'd2749,
    12'd2753, 12'd2767, 12'd2777, 12'd2789, 12'd2791, 12'd2797,
    12'd2801, 12'd2803, 12'd2819, 12'd2833, 12'd2837, 12'd2843, 12'd2851, 12'd2857,
    12'd2861, 12'd2879, 12'd2887, 12'd2897,
    12'd2903, 12'd2909, 12'd2917, 12'd2927, 12'd2939, 12'd2953, 12'd2957, 12'd2963,
    12'd2969, 12'd2971, 12'd2999,
    12'd3001, 12'd3011, 12'd3019, 12'd3023, 12'd3037, 12'd3041, 12'd3049, 12'd3061,
    12'd3067, 12'd3079, 12'd3083, 12'd3089,
    12'd3109, 12'd3119, 12'd3121, 12'd3137, 12'd3163, 12'd3167, 12'd3169, 12'd3181,
    12'd3187, 12'd3191,
    12'd3203, 12'd3209, 12'd3217, 12'd3221, 12'd3229, 12'd3251, 12'd3253, 12'd3257,
    12'd3259, 12'd3271, 12'd3299,
    12'd3301, 12'd3307, 12'd3313, 12'd3319, 12'd3323, 12'd3329, 12'd3331, 12'd3343,
    12'd3347, 12'd3359, 12'd3361, 12'd3371, 12'd3373, 12'd3389, 12'd3391,
    12'd3407, 12'd3413, 12'd3433, 12'd3449, 12'd3457, 12'd3461, 12'd3463, 12'd3467,
    12'd3469, 12'd3491, 12'd3499,
    12'd3511, 12'd3517, 12'd3527, 12'd3529, 12'd3533, 12'd3539, 12'd3541, 12'd3547,
    12'd3557, 12'd3559, 12'd3571, 12'd3581, 12'd3583, 12'd3593,
    12'd3607, 12'd3613, 12'd3617, 12'd3623, 12'd3631, 12'd3637, 12'd3643, 12'd3659,
    12'd3671, 12'd3673, 12'd3677, 12'd3691, 12'd3697,
    12'd3701, 12'd3709, 12'd3719, 12'd3727, 12'd3733, 12'd3739, 12'd3761, 12'd3767,
    12'd3769, 12'd3779, 12'd3793, 12'd3797,
    12'd3803, 12'd3821, 12'd3823, 12'd3833, 12'd3847, 12'd3851, 12'd3853, 12'd3863,
    12'd3877, 12'd3881, 12'd3889,
    12'd3907, 12'd3911, 12'd3917, 12'd3919, 12'd3923, 12'd3929, 12'd3931, 12'd3943,
    12'd3947, 12'd3967, 12'd3989,
    12'd4001, 12'd4003, 12'd4007, 12'd4013, 12'd4019, 12'd4021, 12'd4027, 12'd4049,
    12'd4051, 12'd4057, 12'd4073, 12'd4079, 12'd4091, 12'd4093
  };

endpackage

// ===== sv/dcu_in_if.sv =====
// ----------------------------------------------------------------------------
// dcu_in_if
// Valid/ready channel carrying one value to be factored.
// ----------------------------------------------------------------------------
interface dcu_in_if import dcu_pkg::*;;
  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ===== sv/dcu_out_if.sv =====
// ----------------------------------------------------------------------------
// dcu_out_if
// Valid/ready channel carrying one divisor count.
// ----------------------------------------------------------------------------
interface dcu_out_if import dcu_pkg::*;;
  logic   valid;
  logic   ready;
  count_t divisor_count;

  modport source (output valid, output divisor_count, input ready);
  modport sink   (input valid, input divisor_count, output ready);
endinterface

// ===== sv/dcu_ram.sv =====
// ----------------------------------------------------------------------------
// dcu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dcu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dcu_div.sv =====
// ----------------------------------------------------------------------------
// dcu_div
// Restoring divider: value by prime, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dcu_div import dcu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic   busy;
  logic   done;
  step_t  step;
  value_t quo;
  prime_t rem;
  prime_t dvs;

  logic [PRIME_WIDTH:0] shifted;
  logic [PRIME_WIDTH:0] diff;
  logic                 fits;

  always_comb begin
    shifted = {rem, quo[VALUE_WIDTH-1]};
    diff    = shifted - {1'b0, dvs};
    fits    = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[PRIME_WIDTH-1:0] : shifted[PRIME_WIDTH-1:0];
      quo <= {quo[VALUE_WIDTH-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== sv/divisor_count_unit.sv =====
// ----------------------------------------------------------------------------
// divisor_count_unit
// Number of divisors of a 24-bit value by trial division over a prime table.
// ----------------------------------------------------------------------------
// After reset the prime table RAM is loaded, one entry per cycle; no value is
// taken meanwhile. A value is then factored by trial division over the
// ascending primes while p*p does not exceed what is left. Each prime tried
// goes through a table read, a square check and a 24-step divide, and each
// further factor of a prime found costs another divide. The single bit-serial
// divider sets the time each value takes. One value is worked on at a time;
// the next is taken once the result sits in the output register, even if the
// sink has not taken it yet. A value of zero yields a count of zero.
// ----------------------------------------------------------------------------
module divisor_count_unit import dcu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  dcu_in_if.sink    operand,
  dcu_out_if.source result
);

  state_t   state;
  state_t   state_next;
  index_t   fill_idx;
  index_t   k;
  value_t   rest;
  sat_t     count;
  exp_t     f;
  prime_t   prime;
  logic     out_valid;
  count_t   out_count;

  logic     ram_we;
  prime_t   ram_rdata;
  div_req_t div_req;
  div_rsp_t div_rsp;

  value_t                 square;
  prod_t                  prod;
  sat_t                   count_sat;
  logic [SAT_WIDTH:0]     doubled;
  count_t                 final_count;
  logic                   out_load;

  dcu_ram #(
    .WIDTH (PRIME_WIDTH),
    .DEPTH (PRIME_COUNT)
  ) u_prime_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_idx),
    .wdata (PRIME_TABLE[fill_idx]),
    .raddr (k),
    .rdata (ram_rdata)
  );

  dcu_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    square    = VALUE_WIDTH'(ram_rdata) * VALUE_WIDTH'(ram_rdata);
    prod      = PROD_WIDTH'(count) * PROD_WIDTH'(f + 1'b1);
    count_sat = (prod > PROD_WIDTH'(COUNT_MAX)) ? COUNT_SAT : prod[SAT_WIDTH-1:0];
    // leftover above 1 is one more prime factor
    doubled   = (rest > VALUE_WIDTH'(1)) ? {count, 1'b0} : {1'b0, count};
    final_count = (doubled > (SAT_WIDTH+1)'(COUNT_MAX)) ? COUNT_MAX
                                                        : doubled[COUNT_WIDTH-1:0];
    out_load  = !out_valid || result.ready;
  end

  always_comb begin
    state_next       = state;
    ram_we           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = rest;
    div_req.divisor  = prime;
    case (state)
      ST_FILL: begin
        ram_we = 1'b1;
        if (fill_idx == INDEX_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (operand.valid) begin
          state_next = (operand.value == '0) ? ST_FINAL : ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (ram_rdata < PRIME_WIDTH'(2) || square > rest) begin
          state_next = ST_FINAL;
        end else begin
          div_req.start   = 1'b1;
          div_req.divisor = ram_rdata;
          state_next      = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0) begin
            // divides again: keep going on the quotient
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quotient;
          end else if (k == INDEX_LAST) begin
            state_next = ST_FINAL;
          end else begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_FINAL: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign operand.ready        = (state == ST_IDLE);
  assign result.valid         = out_valid;
  assign result.divisor_count = out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      fill_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FILL && fill_idx != INDEX_LAST) begin
        fill_idx <= fill_idx + 1'b1;
      end
      if (state == ST_FINAL && out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (operand.valid) begin
          rest  <= operand.value;
          count <= (operand.value == '0) ? '0 : SAT_WIDTH'(1);
          k     <= '0;
        end
      end
      ST_CHECK: begin
        prime <= ram_rdata;
        f     <= '0;
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0) begin
            rest <= div_rsp.quotient;
            f    <= f + 1'b1;
          end else begin
            if (f != '0) begin
              count <= count_sat;
            end
            k <= k + 1'b1;
          end
        end
      end
      ST_FINAL: begin
        if (out_load) begin
          out_count <= final_count;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide phase");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH || state == ST_CHECK || state == ST_DIVIDE) |-> count <= COUNT_SAT)
    else $error("running count above saturation value");

  a_rest_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH || state == ST_CHECK || state == ST_DIVIDE) |-> rest != '0)
    else $error("remaining value reached zero during factoring");

  a_load_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == ST_FINAL)
    else $error("result raised without a finished item");
`endif

endmodule
